// ===== hw/rtl/ntc_pkg.sv =====
// shared constants and types for the ntc beta temperature block
`timescale 1ns / 1ps

package ntc_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int SER_W       = 20;
   localparam int BETA_W      = 16;
   localparam int REF_W       = 16;
   localparam int FS_W        = 16;
   localparam int TEMP_W      = 18;
   localparam int IDX_W       = 3;
   localparam int CSR_DW      = 20;

   localparam int NUMR_W   = SER_W + SAMPLE_BITS;
   localparam int DENR_W   = SER_W + FS_W;
   localparam int LOG_W    = (NUMR_W > DENR_W) ? NUMR_W : DENR_W;
   localparam int EXP_W    = 6;
   localparam int MANT_W   = 31;
   localparam int FRAC_W   = 16;
   localparam int SQ_STEPS = FRAC_W;
   localparam int QUO_W    = 17;
   localparam int DIV_W    = 58;
   localparam int LN2_W    = 30;

   localparam logic [LN2_W-1:0] LN2_Q30 = 30'd744261118;

   localparam logic signed [TEMP_W-1:0] TEMP_MAX     = 18'sd99999;
   localparam logic signed [TEMP_W-1:0] TEMP_INVALID = -18'sd99900;
   localparam logic signed [TEMP_W-1:0] ZERO_C_CK    = 18'sd27315;

   localparam logic [IDX_W-1:0] REG_SERIES     = 3'd0;
   localparam logic [IDX_W-1:0] REG_NOMINAL    = 3'd1;
   localparam logic [IDX_W-1:0] REG_BETA       = 3'd2;
   localparam logic [IDX_W-1:0] REG_REF        = 3'd3;
   localparam logic [IDX_W-1:0] REG_FULL_SCALE = 3'd4;

   typedef enum logic [1:0] {
      KIND_NORMAL,
      KIND_INVALID,
      KIND_ZERO_K,
      KIND_HOT
   } kind_type;

   typedef struct packed {
      logic             valid;
      kind_type         kind;
      logic [EXP_W-1:0] exp_n;
      logic [EXP_W-1:0] exp_d;
   } log_side_type;

   typedef struct packed {
      logic     valid;
      kind_type kind;
   } div_side_type;

endpackage

// ===== hw/rtl/ntc_sq_cell.sv =====
// one squaring step of the log2 chain, for numerator and denominator mantissas
`timescale 1ns / 1ps

module ntc_sq_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  ntc_pkg::log_side_type            side_i,
   input  logic [ntc_pkg::MANT_W-1:0]       mant_n_i,
   input  logic [ntc_pkg::MANT_W-1:0]       mant_d_i,
   input  logic [ntc_pkg::FRAC_W-1:0]       frac_n_i,
   input  logic [ntc_pkg::FRAC_W-1:0]       frac_d_i,
   output ntc_pkg::log_side_type            side_o,
   output logic [ntc_pkg::MANT_W-1:0]       mant_n_o,
   output logic [ntc_pkg::MANT_W-1:0]       mant_d_o,
   output logic [ntc_pkg::FRAC_W-1:0]       frac_n_o,
   output logic [ntc_pkg::FRAC_W-1:0]       frac_d_o
);

   logic [2*ntc_pkg::MANT_W-1:0] sq_n, sq_d;
   logic [ntc_pkg::MANT_W:0]     top_n, top_d;
   ntc_pkg::log_side_type        side_ff;
   logic [ntc_pkg::MANT_W-1:0]   mant_n_ff, mant_n_in, mant_d_ff, mant_d_in;
   logic [ntc_pkg::FRAC_W-1:0]   frac_n_ff, frac_n_in, frac_d_ff, frac_d_in;

   always_comb begin
      sq_n  = mant_n_i * mant_n_i;
      sq_d  = mant_d_i * mant_d_i;
      top_n = sq_n[2*ntc_pkg::MANT_W-1 -: ntc_pkg::MANT_W+1];
      top_d = sq_d[2*ntc_pkg::MANT_W-1 -: ntc_pkg::MANT_W+1];
      mant_n_in = top_n[ntc_pkg::MANT_W] ? top_n[ntc_pkg::MANT_W:1]
                                         : top_n[ntc_pkg::MANT_W-1:0];
      mant_d_in = top_d[ntc_pkg::MANT_W] ? top_d[ntc_pkg::MANT_W:1]
                                         : top_d[ntc_pkg::MANT_W-1:0];
      frac_n_in = {frac_n_i[ntc_pkg::FRAC_W-2:0], top_n[ntc_pkg::MANT_W]};
      frac_d_in = {frac_d_i[ntc_pkg::FRAC_W-2:0], top_d[ntc_pkg::MANT_W]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= '0;
      end else begin
         side_ff <= side_i;
      end
      mant_n_ff <= mant_n_in;
      mant_d_ff <= mant_d_in;
      frac_n_ff <= frac_n_in;
      frac_d_ff <= frac_d_in;
   end

   assign side_o   = side_ff;
   assign mant_n_o = mant_n_ff;
   assign mant_d_o = mant_d_ff;
   assign frac_n_o = frac_n_ff;
   assign frac_d_o = frac_d_ff;

endmodule

// ===== hw/rtl/ntc_div_cell.sv =====
// one restoring division step, one quotient bit per cell
`timescale 1ns / 1ps

module ntc_div_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  ntc_pkg::div_side_type       side_i,
   input  logic [ntc_pkg::DIV_W-1:0]   rem_i,
   input  logic [ntc_pkg::DIV_W-1:0]   dvs_i,
   input  logic [ntc_pkg::QUO_W-1:0]   quo_i,
   output ntc_pkg::div_side_type       side_o,
   output logic [ntc_pkg::DIV_W-1:0]   rem_o,
   output logic [ntc_pkg::DIV_W-1:0]   dvs_o,
   output logic [ntc_pkg::QUO_W-1:0]   quo_o
);

   logic                         ge;
   ntc_pkg::div_side_type        side_ff;
   logic [ntc_pkg::DIV_W-1:0]    rem_ff, rem_in, dvs_ff, dvs_in;
   logic [ntc_pkg::QUO_W-1:0]    quo_ff, quo_in;

   always_comb begin
      ge     = (rem_i >= dvs_i);
      rem_in = ge ? (rem_i - dvs_i) : rem_i;
      dvs_in = dvs_i >> 1;
      quo_in = {quo_i[ntc_pkg::QUO_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= '0;
      end else begin
         side_ff <= side_i;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign side_o = side_ff;
   assign rem_o  = rem_ff;
   assign dvs_o  = dvs_ff;
   assign quo_o  = quo_ff;

endmodule

// ===== hw/rtl/ntc_beta_temperature.sv =====
// top level: ntc thermistor sample to temperature in 0.01 degC via the beta equation
`timescale 1ns / 1ps

// Fully pipelined: a new sample is taken in every cycle (busy stays low). Its result is
// driven on the rsp_ ports from the output register, strobed by rsp_valid for one cycle;
// the receiver cannot stall. The pipeline has 45 register stages: the 16 squaring cells of
// the log2 chain and the 17 restoring division cells, plus 12 stages of product,
// normalize, log, divisor and output logic. Registers are written through the csr_
// channel, which is always ready; write them only with no sample in flight.

module ntc_beta_temperature (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [ntc_pkg::SAMPLE_BITS-1:0]     req_adc_sample,
   output logic                                rsp_valid,
   output logic signed [ntc_pkg::TEMP_W-1:0]   rsp_temp_centi,
   output logic                                rsp_valid_res,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ntc_pkg::IDX_W-1:0]           csr_index,
   input  logic [ntc_pkg::CSR_DW-1:0]          csr_wdata
);

   localparam int MAG_W  = ntc_pkg::EXP_W + ntc_pkg::FRAC_W;
   localparam int D_W    = MAG_W + 1;
   localparam int PROD_W = MAG_W + ntc_pkg::LN2_W;
   localparam int LQ_W   = MAG_W + 1;
   localparam int RB_W   = ntc_pkg::REF_W + ntc_pkg::BETA_W;
   localparam int NUMC_W = RB_W + 7;
   localparam int LQR_W  = LQ_W + ntc_pkg::REF_W + 1;
   localparam int BASE_W = ntc_pkg::BETA_W + 7 + 16;
   localparam int DEN_W  = 42;

   function automatic logic [ntc_pkg::EXP_W-1:0] lead_one(input logic [ntc_pkg::LOG_W-1:0] v);
      logic [ntc_pkg::EXP_W-1:0] e;
      e = '0;
      for (int i = 0; i < ntc_pkg::LOG_W; i++) begin
         if (v[i]) e = ntc_pkg::EXP_W'(i);
      end
      return e;
   endfunction

   // registers
   logic [ntc_pkg::SER_W-1:0]  series_ff, nominal_ff;
   logic [ntc_pkg::BETA_W-1:0] beta_ff;
   logic [ntc_pkg::REF_W-1:0]  ref_ff;
   logic [ntc_pkg::FS_W-1:0]   fs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         series_ff  <= 20'd10000;
         nominal_ff <= 20'd10000;
         beta_ff    <= 16'd3950;
         ref_ff     <= 16'd29815;
         fs_ff      <= 16'd4095;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ntc_pkg::REG_SERIES:     series_ff  <= csr_wdata;
            ntc_pkg::REG_NOMINAL:    nominal_ff <= csr_wdata;
            ntc_pkg::REG_BETA:       beta_ff    <= csr_wdata[ntc_pkg::BETA_W-1:0];
            ntc_pkg::REG_REF:        ref_ff     <= csr_wdata[ntc_pkg::REF_W-1:0];
            ntc_pkg::REG_FULL_SCALE: fs_ff      <= csr_wdata[ntc_pkg::FS_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   // front stages: sample, products, exponent, normalize
   logic                            v1_ff;
   logic [ntc_pkg::SAMPLE_BITS-1:0] s1_ff;
   ntc_pkg::div_side_type           p2_side_ff, p2_side_in;
   logic [ntc_pkg::NUMR_W-1:0]      numr_ff, numr_in;
   logic [ntc_pkg::DENR_W-1:0]      denr_ff, denr_in;
   logic [ntc_pkg::FS_W-1:0]        s16;
   ntc_pkg::log_side_type           p3_side_ff, p3_side_in, p4_side_ff;
   logic [ntc_pkg::LOG_W-1:0]       wn3_ff, wd3_ff, wn_sh, wd_sh;
   logic [ntc_pkg::MANT_W-1:0]      mn4_ff, md4_ff;

   always_comb begin
      s16     = ntc_pkg::FS_W'(s1_ff);
      numr_in = series_ff * s1_ff;
      denr_in = nominal_ff * (fs_ff - s16);
      p2_side_in.valid = v1_ff;
      if (s1_ff == '0 || s16 >= fs_ff) begin
         p2_side_in.kind = ntc_pkg::KIND_INVALID;
      end else if (series_ff == '0 || nominal_ff == '0 || beta_ff == '0 || ref_ff == '0) begin
         p2_side_in.kind = ntc_pkg::KIND_ZERO_K;
      end else begin
         p2_side_in.kind = ntc_pkg::KIND_NORMAL;
      end
      p3_side_in.valid = p2_side_ff.valid;
      p3_side_in.kind  = p2_side_ff.kind;
      p3_side_in.exp_n = lead_one(ntc_pkg::LOG_W'(numr_ff));
      p3_side_in.exp_d = lead_one(ntc_pkg::LOG_W'(denr_ff));
      wn_sh = wn3_ff << (ntc_pkg::EXP_W'(ntc_pkg::LOG_W - 1) - p3_side_ff.exp_n);
      wd_sh = wd3_ff << (ntc_pkg::EXP_W'(ntc_pkg::LOG_W - 1) - p3_side_ff.exp_d);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff      <= 1'b0;
         p2_side_ff <= '0;
         p3_side_ff <= '0;
         p4_side_ff <= '0;
      end else begin
         v1_ff      <= start && !busy;
         p2_side_ff <= p2_side_in;
         p3_side_ff <= p3_side_in;
         p4_side_ff <= p3_side_ff;
      end
      s1_ff   <= req_adc_sample;
      numr_ff <= numr_in;
      denr_ff <= denr_in;
      wn3_ff  <= ntc_pkg::LOG_W'(numr_ff);
      wd3_ff  <= ntc_pkg::LOG_W'(denr_ff);
      mn4_ff  <= wn_sh[ntc_pkg::LOG_W-1 -: ntc_pkg::MANT_W];
      md4_ff  <= wd_sh[ntc_pkg::LOG_W-1 -: ntc_pkg::MANT_W];
   end

   // log2 fraction chain
   ntc_pkg::log_side_type        sq_side [0:ntc_pkg::SQ_STEPS];
   logic [ntc_pkg::MANT_W-1:0]   sq_mn   [0:ntc_pkg::SQ_STEPS];
   logic [ntc_pkg::MANT_W-1:0]   sq_md   [0:ntc_pkg::SQ_STEPS];
   logic [ntc_pkg::FRAC_W-1:0]   sq_fn   [0:ntc_pkg::SQ_STEPS];
   logic [ntc_pkg::FRAC_W-1:0]   sq_fd   [0:ntc_pkg::SQ_STEPS];

   assign sq_side[0] = p4_side_ff;
   assign sq_mn[0]   = mn4_ff;
   assign sq_md[0]   = md4_ff;
   assign sq_fn[0]   = '0;
   assign sq_fd[0]   = '0;

   for (genvar g = 0; g < ntc_pkg::SQ_STEPS; g++) begin : g_sq
      ntc_sq_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .side_i   (sq_side[g]),
         .mant_n_i (sq_mn[g]),
         .mant_d_i (sq_md[g]),
         .frac_n_i (sq_fn[g]),
         .frac_d_i (sq_fd[g]),
         .side_o   (sq_side[g+1]),
         .mant_n_o (sq_mn[g+1]),
         .mant_d_o (sq_md[g+1]),
         .frac_n_o (sq_fn[g+1]),
         .frac_d_o (sq_fd[g+1])
      );
   end

   // log difference, natural log, divisor, dividend
   ntc_pkg::log_side_type     sq_last;
   ntc_pkg::div_side_type     p5_side_ff, p6_side_ff, p7_side_ff, p8_side_ff;
   ntc_pkg::div_side_type     p9_side_ff, p9_side_in, p10_side_ff, p11_side_ff, p11_side_in;
   logic signed [D_W-1:0]     diff;
   logic [MAG_W-1:0]          mag_ff;
   logic                      neg5_ff, neg6_ff;
   logic [PROD_W-1:0]         prod_ff, rnd;
   logic signed [LQ_W-1:0]    lq_ff, lq_in;
   logic [RB_W-1:0]           rb_ff;
   logic signed [LQR_W-1:0]   lqr_ff;
   logic [NUMC_W-1:0]         numc_ff;
   logic [BASE_W-1:0]         base;
   logic signed [DEN_W-1:0]   den_ff, den_in;
   logic [ntc_pkg::DIV_W-1:0] num55_ff, adj_ff, adj_in, lim;
   logic [DEN_W-2:0]          denu_ff;
   logic [ntc_pkg::DIV_W-1:0] rem11_ff, dvs11_ff;

   always_comb begin
      sq_last = sq_side[ntc_pkg::SQ_STEPS];
      diff = $signed({1'b0, sq_last.exp_n, sq_fn[ntc_pkg::SQ_STEPS]})
           - $signed({1'b0, sq_last.exp_d, sq_fd[ntc_pkg::SQ_STEPS]});
      rnd   = prod_ff + (PROD_W'(1) << (ntc_pkg::LN2_W - 1));
      lq_in = neg6_ff ? -$signed({1'b0, rnd[PROD_W-1 -: MAG_W]})
                      :  $signed({1'b0, rnd[PROD_W-1 -: MAG_W]});
      base  = {(BASE_W - 16)'(beta_ff) * 7'd100, 16'b0};
      den_in = $signed({3'b0, base}) + DEN_W'(lqr_ff);
      p9_side_in = p8_side_ff;
      if (p8_side_ff.kind == ntc_pkg::KIND_NORMAL && den_in <= 0) begin
         p9_side_in.kind = ntc_pkg::KIND_HOT;
      end
      adj_in = num55_ff + ntc_pkg::DIV_W'(den_ff[DEN_W-1:1]);
      lim    = ntc_pkg::DIV_W'(denu_ff) << ntc_pkg::QUO_W;
      p11_side_in = p10_side_ff;
      if (p10_side_ff.kind == ntc_pkg::KIND_NORMAL && adj_ff >= lim) begin
         p11_side_in.kind = ntc_pkg::KIND_HOT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p5_side_ff  <= '0;
         p6_side_ff  <= '0;
         p7_side_ff  <= '0;
         p8_side_ff  <= '0;
         p9_side_ff  <= '0;
         p10_side_ff <= '0;
         p11_side_ff <= '0;
      end else begin
         p5_side_ff  <= '{valid: sq_last.valid, kind: sq_last.kind};
         p6_side_ff  <= p5_side_ff;
         p7_side_ff  <= p6_side_ff;
         p8_side_ff  <= p7_side_ff;
         p9_side_ff  <= p9_side_in;
         p10_side_ff <= p9_side_ff;
         p11_side_ff <= p11_side_in;
      end
      neg5_ff  <= diff[D_W-1];
      mag_ff   <= diff[D_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
      neg6_ff  <= neg5_ff;
      prod_ff  <= mag_ff * ntc_pkg::LN2_Q30;
      lq_ff    <= lq_in;
      rb_ff    <= ref_ff * beta_ff;
      lqr_ff   <= lq_ff * $signed({1'b0, ref_ff});
      numc_ff  <= rb_ff * 7'd100;
      den_ff   <= den_in;
      num55_ff <= ntc_pkg::DIV_W'({numc_ff, 16'b0});
      adj_ff   <= adj_in;
      denu_ff  <= den_ff[DEN_W-2:0];
      rem11_ff <= adj_ff;
      dvs11_ff <= ntc_pkg::DIV_W'(denu_ff) << (ntc_pkg::QUO_W - 1);
   end

   // division chain
   ntc_pkg::div_side_type       dv_side [0:ntc_pkg::QUO_W];
   logic [ntc_pkg::DIV_W-1:0]   dv_rem  [0:ntc_pkg::QUO_W];
   logic [ntc_pkg::DIV_W-1:0]   dv_dvs  [0:ntc_pkg::QUO_W];
   logic [ntc_pkg::QUO_W-1:0]   dv_quo  [0:ntc_pkg::QUO_W];

   assign dv_side[0] = p11_side_ff;
   assign dv_rem[0]  = rem11_ff;
   assign dv_dvs[0]  = dvs11_ff;
   assign dv_quo[0]  = '0;

   for (genvar g = 0; g < ntc_pkg::QUO_W; g++) begin : g_div
      ntc_div_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .side_i (dv_side[g]),
         .rem_i  (dv_rem[g]),
         .dvs_i  (dv_dvs[g]),
         .quo_i  (dv_quo[g]),
         .side_o (dv_side[g+1]),
         .rem_o  (dv_rem[g+1]),
         .dvs_o  (dv_dvs[g+1]),
         .quo_o  (dv_quo[g+1])
      );
   end

   // output stage
   ntc_pkg::div_side_type              dv_last;
   logic signed [ntc_pkg::TEMP_W-1:0]  t_c, temp_ff, temp_in;
   logic                               rsp_valid_ff, vres_ff, vres_in;

   always_comb begin
      dv_last = dv_side[ntc_pkg::QUO_W];
      t_c = $signed({1'b0, dv_quo[ntc_pkg::QUO_W]}) - ntc_pkg::ZERO_C_CK;
      case (dv_last.kind)
         ntc_pkg::KIND_NORMAL: begin
            temp_in = (t_c > ntc_pkg::TEMP_MAX) ? ntc_pkg::TEMP_MAX : t_c;
            vres_in = 1'b1;
         end
         ntc_pkg::KIND_INVALID: begin
            temp_in = ntc_pkg::TEMP_INVALID;
            vres_in = 1'b0;
         end
         ntc_pkg::KIND_ZERO_K: begin
            temp_in = -ntc_pkg::ZERO_C_CK;
            vres_in = 1'b1;
         end
         default: begin
            temp_in = ntc_pkg::TEMP_MAX;
            vres_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_last.valid;
      end
      temp_ff <= temp_in;
      vres_ff <= vres_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_temp_centi = temp_ff;
   assign rsp_valid_res  = vres_ff;

   a_invalid_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_temp_centi == ntc_pkg::TEMP_INVALID)
      else $error("invalid result without marker code");

   a_upper_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_temp_centi <= ntc_pkg::TEMP_MAX)
      else $error("result above saturation limit");

   a_lower_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res |-> rsp_temp_centi >= -ntc_pkg::ZERO_C_CK)
      else $error("valid result below absolute zero");

   a_hot_sat: assert property (@(posedge clock) disable iff (reset)
      dv_last.valid && dv_last.kind == ntc_pkg::KIND_HOT |=>
         rsp_valid && rsp_temp_centi == ntc_pkg::TEMP_MAX)
      else $error("overflow transfer not saturated");

endmodule
